// ----- design/ert_pkg.sv -----
// ----------------------------------------------------------------------------
// ert_pkg
// Shared types, codes and defaults of the epoch reclamation tracker.
// ----------------------------------------------------------------------------
`default_nettype none

package ert_pkg;

    // Default table sizes.
    localparam int CPU_SLOTS_DEF    = 16;
    localparam int THREAD_SLOTS_DEF = 32;
    localparam int FREE_DEPTH_DEF   = 32;

    // Field widths.
    localparam int EPOCH_W  = 63;
    localparam int HANDLE_W = 32;
    localparam int KEY_W    = 64;
    localparam int SAFE_W   = 64;

    typedef logic [EPOCH_W-1:0]  epoch_t;
    typedef logic [HANDLE_W-1:0] handle_t;

    localparam epoch_t EPOCH_MAX = '1;

    // Input item kinds.
    localparam logic [2:0] KIND_ENTER   = 3'd0;
    localparam logic [2:0] KIND_EXIT    = 3'd1;
    localparam logic [2:0] KIND_FREE    = 3'd2;
    localparam logic [2:0] KIND_FLUSH   = 3'd3;
    localparam logic [2:0] KIND_REFRESH = 3'd4;
    localparam logic [2:0] KIND_DRAIN   = 3'd5;

    // Result status codes.
    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_CPU_RANGE = 2'd1;
    localparam logic [1:0] ST_THR_FULL  = 2'd2;
    localparam logic [1:0] ST_FIFO_FULL = 2'd3;

    // Configuration register indexes.
    localparam logic [1:0] CFG_PERCPU    = 2'd0;
    localparam logic [1:0] CFG_CPU_COUNT = 2'd1;

    // Occupancy flags of the free queue.
    typedef struct packed {
        logic empty;
        logic full;
    } ert_fifo_stat_t;

endpackage

`default_nettype wire

// ----- design/ert_free_fifo.sv -----
// ----------------------------------------------------------------------------
// ert_free_fifo
// Queue of freed handles with their stamp epochs, kept in a synchronous
// memory. The head entry is read every cycle through a register.
// ----------------------------------------------------------------------------
`default_nettype none

module ert_free_fifo
    import ert_pkg::*;
#(
    parameter int DEPTH = FREE_DEPTH_DEF
) (
    input  wire logic           aclk,
    input  wire logic           aresetn,
    input  wire logic           push,
    input  wire handle_t        push_handle,
    input  wire epoch_t         push_epoch,
    input  wire logic           pop,
    output ert_fifo_stat_t      stat,
    output handle_t             head_handle,
    output epoch_t              head_epoch
);

    localparam int FW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);
    localparam int SW = CW + 1;

    logic [FW-1:0] head_reg;
    logic [CW-1:0] count_reg;
    logic [SW-1:0] tail_sum;
    logic [SW-1:0] tail_wrap;
    logic [FW-1:0] tail_idx;
    logic [FW-1:0] head_inc;

    handle_t hmem [DEPTH];
    epoch_t  emem [DEPTH];
    handle_t head_h_reg;
    epoch_t  head_e_reg;

    // Tail position wraps once, since head plus count stays below twice the depth.
    assign tail_sum  = SW'(head_reg) + SW'(count_reg);
    assign tail_wrap = (tail_sum >= SW'(DEPTH)) ? tail_sum - SW'(DEPTH) : tail_sum;
    assign tail_idx  = tail_wrap[FW-1:0];
    assign head_inc  = (head_reg == FW'(DEPTH - 1)) ? '0 : head_reg + 1'b1;

    assign stat.empty  = (count_reg == '0);
    assign stat.full   = (count_reg == CW'(DEPTH));
    assign head_handle = head_h_reg;
    assign head_epoch  = head_e_reg;

    // Pointer and count.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            head_reg  <= '0;
            count_reg <= '0;
        end else begin
            if (pop) begin
                head_reg  <= head_inc;
                count_reg <= count_reg - 1'b1;
            end else if (push) begin
                count_reg <= count_reg + 1'b1;
            end
        end
    end

    // Storage with a registered read of the head entry.
    always_ff @(posedge aclk) begin
        if (push) begin
            hmem[tail_idx] <= push_handle;
            emem[tail_idx] <= push_epoch;
        end
        head_h_reg <= hmem[head_reg];
        head_e_reg <= emem[head_reg];
    end

    a_push_room: assert property (@(posedge aclk) disable iff (!aresetn)
        push |-> !stat.full) else $error("push into a full free queue");
    a_pop_data: assert property (@(posedge aclk) disable iff (!aresetn)
        pop |-> !stat.empty && !push) else $error("bad pop of the free queue");
    a_count_cap: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CW'(DEPTH)) else $error("free queue count past depth");

endmodule

`default_nettype wire

// ----- design/epoch_reclamation_tracker.sv -----
// ----------------------------------------------------------------------------
// epoch_reclamation_tracker
// Global epoch, per-CPU reader epochs, thread reader table and a queue of
// freed handles; flush and drain release handles that are safe to reclaim.
//
//   Channel  Direction  Handshake          Word
//   s_       in         s_valid/s_ready    one command
//   m_       out        m_valid/m_ready    one result, last marks the end
//   cfg_     in         cfg_valid/cfg_ready register index and data
//
// Free, CPU enter/exit, refresh and unused kinds go from idle to the emit
// state. A thread enter or exit scans the filled thread entries. Flush scans
// the CPU table (in per-CPU mode) and the thread table, then reads and checks
// each queue head in the release loop.
// Reset is synchronous; the CPU table reads as epoch 1 until written.
// A stalled output holds the engine only when it has a new word to give.
// ----------------------------------------------------------------------------
`default_nettype none

module epoch_reclamation_tracker
    import ert_pkg::*;
#(
    parameter int CPU_SLOTS    = CPU_SLOTS_DEF,
    parameter int THREAD_SLOTS = THREAD_SLOTS_DEF,
    parameter int FREE_DEPTH   = FREE_DEPTH_DEF
) (
    input  wire logic                     aclk,
    input  wire logic                     aresetn,
    input  wire logic                     s_valid,
    output logic                          s_ready,
    input  wire logic [2:0]               s_kind,
    input  wire logic                     s_preemptable,
    input  wire logic [7:0]               s_cpu_index,
    input  wire logic [KEY_W-1:0]         s_thread_key,
    input  wire logic [HANDLE_W-1:0]      s_handle,
    output logic                          m_valid,
    input  wire logic                     m_ready,
    output logic [1:0]                    m_status,
    output logic                          m_released,
    output logic [HANDLE_W-1:0]           m_released_handle,
    output logic signed [SAFE_W-1:0]      m_safe_epoch,
    output logic                          m_last,
    input  wire logic                     cfg_valid,
    output logic                          cfg_ready,
    input  wire logic [1:0]               cfg_index,
    input  wire logic [4:0]               cfg_data
);

    localparam int CW  = (CPU_SLOTS > 1) ? $clog2(CPU_SLOTS) : 1;
    localparam int TW  = (THREAD_SLOTS > 1) ? $clog2(THREAD_SLOTS) : 1;
    localparam int TCW = $clog2(THREAD_SLOTS + 1);
    localparam int LW  = 12;

    typedef enum logic [2:0] {
        S_IDLE, S_TSCAN, S_CSCAN, S_FSCAN, S_REL_RD, S_REL_CHK, S_EMIT
    } state_t;

    // Control and working registers.
    state_t             state_reg, state_next;
    logic               percpu_reg, percpu_next;
    logic [4:0]         cpu_count_reg, cpu_count_next;
    epoch_t             global_reg, global_next;
    logic [TCW-1:0]     fill_reg, fill_next;
    logic [LW-1:0]      idx_reg, idx_next;
    logic               rd_vld_reg, rd_vld_next;
    logic [LW-1:0]      rd_idx_reg, rd_idx_next;
    epoch_t             low_reg, low_next;
    logic               all_reg, all_next;
    epoch_t             limit_reg, limit_next;
    logic [SAFE_W-1:0]  safe_reg, safe_next;
    logic               held_vld_reg, held_vld_next;
    handle_t            held_h_reg, held_h_next;
    logic [1:0]         st_reg, st_next;
    logic [KEY_W-1:0]   key_reg, key_next;
    logic               exit_reg, exit_next;

    // Output register.
    logic               m_valid_reg, m_valid_next;
    logic [1:0]         m_status_reg, m_status_next;
    logic               m_rel_reg, m_rel_next;
    handle_t            m_h_reg, m_h_next;
    logic [SAFE_W-1:0]  m_safe_reg, m_safe_next;
    logic               m_last_reg, m_last_next;

    // Memory ports.
    epoch_t             cmem [CPU_SLOTS];
    logic [CPU_SLOTS-1:0] cwritten_reg;
    logic               cw_en;
    logic [CW-1:0]      cw_addr;
    epoch_t             c_rdata_reg;
    logic               c_rwr_reg;
    epoch_t             c_epoch;

    logic [KEY_W-1:0]   tmem_tag [THREAD_SLOTS];
    epoch_t             tmem_ep  [THREAD_SLOTS];
    logic               tw_en;
    logic [TW-1:0]      tw_addr;
    epoch_t             tw_epoch;
    logic [KEY_W-1:0]   t_tag_reg;
    epoch_t             t_ep_reg;

    logic               push, pop;
    ert_fifo_stat_t     fstat;
    handle_t            head_handle;
    epoch_t             head_epoch;

    logic               accept, out_free, out_load;
    logic [8:0]         cpus_used;
    logic               cpu_ok;
    logic [LW-1:0]      scan_limit;
    logic               issue;
    logic               take_head;

    assign accept    = s_valid && s_ready;
    assign s_ready   = (state_reg == S_IDLE);
    assign cfg_ready = 1'b1;
    assign out_free  = !m_valid_reg || m_ready;

    assign cpus_used = ({4'b0, cpu_count_reg} < 9'(CPU_SLOTS)) ?
                       {4'b0, cpu_count_reg} : 9'(CPU_SLOTS);
    assign cpu_ok    = percpu_reg && ({1'b0, s_cpu_index} < cpus_used);
    assign c_epoch   = c_rwr_reg ? c_rdata_reg : epoch_t'(1);
    assign cw_addr   = s_cpu_index[CW-1:0];

    assign m_valid           = m_valid_reg;
    assign m_status          = m_status_reg;
    assign m_released        = m_rel_reg;
    assign m_released_handle = m_h_reg;
    assign m_safe_epoch      = m_safe_reg;
    assign m_last            = m_last_reg;

    ert_free_fifo #(.DEPTH(FREE_DEPTH)) u_fifo (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .push        (push),
        .push_handle (s_handle),
        .push_epoch  (global_reg),
        .pop         (pop),
        .stat        (fstat),
        .head_handle (head_handle),
        .head_epoch  (head_epoch)
    );

    // CPU table: written entries tracked by flags, unwritten ones read as 1.
    always_ff @(posedge aclk) begin
        if (cw_en) begin
            cmem[cw_addr] <= global_reg;
        end
        c_rdata_reg <= cmem[idx_reg[CW-1:0]];
        c_rwr_reg   <= cwritten_reg[idx_reg[CW-1:0]];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cwritten_reg <= '0;
        end else if (cw_en) begin
            cwritten_reg[cw_addr] <= 1'b1;
        end
    end

    // Thread table: entries fill from the bottom and are never removed.
    always_ff @(posedge aclk) begin
        if (tw_en) begin
            tmem_tag[tw_addr] <= key_reg;
            tmem_ep[tw_addr]  <= tw_epoch;
        end
        t_tag_reg <= tmem_tag[idx_reg[TW-1:0]];
        t_ep_reg  <= tmem_ep[idx_reg[TW-1:0]];
    end

    // Command sequencer.
    always_comb begin
        state_next     = state_reg;
        percpu_next    = percpu_reg;
        cpu_count_next = cpu_count_reg;
        global_next    = global_reg;
        fill_next      = fill_reg;
        idx_next       = idx_reg;
        rd_vld_next    = 1'b0;
        rd_idx_next    = idx_reg;
        low_next       = low_reg;
        all_next       = all_reg;
        limit_next     = limit_reg;
        safe_next      = safe_reg;
        held_vld_next  = held_vld_reg;
        held_h_next    = held_h_reg;
        st_next        = st_reg;
        key_next       = key_reg;
        exit_next      = exit_reg;
        m_status_next  = m_status_reg;
        m_rel_next     = m_rel_reg;
        m_h_next       = m_h_reg;
        m_safe_next    = m_safe_reg;
        m_last_next    = m_last_reg;
        cw_en          = 1'b0;
        tw_en          = 1'b0;
        tw_addr        = rd_idx_reg[TW-1:0];
        tw_epoch       = exit_reg ? '0 : global_reg;
        push           = 1'b0;
        pop            = 1'b0;
        out_load       = 1'b0;
        take_head      = 1'b0;

        scan_limit = (state_reg == S_CSCAN) ? LW'(cpus_used) : LW'(fill_reg);
        issue      = (idx_reg < scan_limit);

        // Configuration writes.
        if (cfg_valid && cfg_ready) begin
            case (cfg_index)
                CFG_PERCPU:    percpu_next    = cfg_data[0];
                CFG_CPU_COUNT: cpu_count_next = cfg_data;
                default:       ;
            endcase
        end

        case (state_reg)
            S_IDLE: begin
                if (accept) begin
                    st_next = ST_OK;
                    case (s_kind)
                        KIND_ENTER, KIND_EXIT: begin
                            if (s_preemptable || !percpu_reg) begin
                                key_next   = s_thread_key;
                                exit_next  = (s_kind == KIND_EXIT);
                                idx_next   = '0;
                                state_next = S_TSCAN;
                            end else begin
                                cw_en      = cpu_ok;
                                st_next    = cpu_ok ? ST_OK : ST_CPU_RANGE;
                                state_next = S_EMIT;
                            end
                        end
                        KIND_FREE: begin
                            if (fstat.full) begin
                                st_next = ST_FIFO_FULL;
                            end else begin
                                push = 1'b1;
                                if (global_reg != EPOCH_MAX) begin
                                    global_next = global_reg + 1'b1;
                                end
                            end
                            state_next = S_EMIT;
                        end
                        KIND_FLUSH: begin
                            low_next      = EPOCH_MAX;
                            idx_next      = '0;
                            held_vld_next = 1'b0;
                            state_next    = percpu_reg ? S_CSCAN : S_FSCAN;
                        end
                        KIND_REFRESH: begin
                            cw_en      = cpu_ok;
                            st_next    = cpu_ok ? ST_OK : ST_CPU_RANGE;
                            state_next = S_EMIT;
                        end
                        KIND_DRAIN: begin
                            all_next      = 1'b1;
                            safe_next     = SAFE_W'(EPOCH_MAX);
                            held_vld_next = 1'b0;
                            state_next    = S_REL_RD;
                        end
                        default: begin
                            state_next = S_EMIT;
                        end
                    endcase
                end
            end

            // Thread lookup: the word read last cycle is checked against the key.
            S_TSCAN: begin
                rd_vld_next = issue;
                if (issue) begin
                    idx_next = idx_reg + 1'b1;
                end
                if (rd_vld_reg && t_tag_reg == key_reg) begin
                    tw_en       = 1'b1;
                    st_next     = ST_OK;
                    rd_vld_next = 1'b0;
                    state_next  = S_EMIT;
                end else if (!rd_vld_reg && !issue) begin
                    if (fill_reg < TCW'(THREAD_SLOTS)) begin
                        tw_en     = 1'b1;
                        tw_addr   = fill_reg[TW-1:0];
                        fill_next = fill_reg + 1'b1;
                        st_next   = ST_OK;
                    end else begin
                        st_next = ST_THR_FULL;
                    end
                    state_next = S_EMIT;
                end
            end

            // Lowest nonzero epoch over the CPU entries in use.
            S_CSCAN: begin
                rd_vld_next = issue;
                if (issue) begin
                    idx_next = idx_reg + 1'b1;
                end
                if (rd_vld_reg) begin
                    if (c_epoch != '0 && c_epoch < low_reg) begin
                        low_next = c_epoch;
                    end
                end else if (!issue) begin
                    idx_next   = '0;
                    state_next = S_FSCAN;
                end
            end

            // Lowest nonzero epoch over the filled thread entries.
            S_FSCAN: begin
                rd_vld_next = issue;
                if (issue) begin
                    idx_next = idx_reg + 1'b1;
                end
                if (rd_vld_reg) begin
                    if (t_ep_reg != '0 && t_ep_reg < low_reg) begin
                        low_next = t_ep_reg;
                    end
                end else if (!issue) begin
                    all_next   = (low_reg == EPOCH_MAX);
                    limit_next = low_reg - 1'b1;
                    safe_next  = SAFE_W'(low_reg - 1'b1);
                    state_next = S_REL_RD;
                end
            end

            // Head word is read; an empty queue ends the release.
            S_REL_RD: begin
                if (!fstat.empty) begin
                    state_next = S_REL_CHK;
                end else if (out_free) begin
                    out_load   = 1'b1;
                    state_next = S_IDLE;
                end
            end

            // The newest release is held back until the next head decides last.
            S_REL_CHK: begin
                if (all_reg || head_epoch <= limit_reg) begin
                    if (!held_vld_reg || out_free) begin
                        out_load      = held_vld_reg;
                        take_head     = 1'b1;
                        pop           = 1'b1;
                        held_vld_next = 1'b1;
                        held_h_next   = head_handle;
                        state_next    = S_REL_RD;
                    end
                end else if (out_free) begin
                    out_load   = 1'b1;
                    state_next = S_IDLE;
                end
            end

            S_EMIT: begin
                if (out_free) begin
                    out_load   = 1'b1;
                    state_next = S_IDLE;
                end
            end

            default: begin
                state_next = S_IDLE;
            end
        endcase

        // Result word contents.
        if (out_load) begin
            if (state_reg == S_EMIT) begin
                m_status_next = st_reg;
                m_rel_next    = 1'b0;
                m_h_next      = '0;
                m_safe_next   = '0;
                m_last_next   = 1'b1;
            end else begin
                m_status_next = ST_OK;
                m_rel_next    = held_vld_reg;
                m_h_next      = held_vld_reg ? held_h_reg : '0;
                m_safe_next   = safe_reg;
                m_last_next   = !take_head;
            end
        end

        m_valid_next = out_load || (m_valid_reg && !m_ready);
    end

    // State and registered outputs.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= S_IDLE;
            percpu_reg    <= 1'b1;
            cpu_count_reg <= 5'd16;
            global_reg    <= epoch_t'(1);
            fill_reg      <= '0;
            rd_vld_reg    <= 1'b0;
            held_vld_reg  <= 1'b0;
            m_valid_reg   <= 1'b0;
        end else begin
            state_reg     <= state_next;
            percpu_reg    <= percpu_next;
            cpu_count_reg <= cpu_count_next;
            global_reg    <= global_next;
            fill_reg      <= fill_next;
            rd_vld_reg    <= rd_vld_next;
            held_vld_reg  <= held_vld_next;
            m_valid_reg   <= m_valid_next;
        end
        idx_reg      <= idx_next;
        rd_idx_reg   <= rd_idx_next;
        low_reg      <= low_next;
        all_reg      <= all_next;
        limit_reg    <= limit_next;
        safe_reg     <= safe_next;
        held_h_reg   <= held_h_next;
        st_reg       <= st_next;
        key_reg      <= key_next;
        exit_reg     <= exit_next;
        m_status_reg <= m_status_next;
        m_rel_reg    <= m_rel_next;
        m_h_reg      <= m_h_next;
        m_safe_reg   <= m_safe_next;
        m_last_reg   <= m_last_next;
    end

    a_fill_cap: assert property (@(posedge aclk) disable iff (!aresetn)
        fill_reg <= TCW'(THREAD_SLOTS)) else $error("thread fill past table size");
    a_epoch_mono: assert property (@(posedge aclk) disable iff (!aresetn)
        1'b1 |=> global_reg >= $past(global_reg)) else $error("global epoch went back");
    a_load_room: assert property (@(posedge aclk) disable iff (!aresetn)
        out_load |-> out_free) else $error("result word overwritten");
    a_pop_rel: assert property (@(posedge aclk) disable iff (!aresetn)
        pop |-> state_reg == S_REL_CHK) else $error("queue pop outside release");

endmodule

`default_nettype wire

// ----- tb/testbench.sv -----
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the epoch reclamation tracker. A behavioral copy of
// the epoch, CPU, thread and free-queue state predicts every result word;
// words leaving the block are compared in order. Directed cases cover each
// kind and corner, then random traffic runs under several register settings.
// ----------------------------------------------------------------------------
`default_nettype none

module testbench
    import ert_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int NCPU = 16;
    localparam int NTHR = 32;
    localparam int NFREE = 32;
    localparam longint unsigned LIMIT_CYCLES = 2_000_000;

    typedef struct packed {
        logic [1:0]  status;
        logic        released;
        logic [31:0] rhandle;
        logic [63:0] safe;
        logic        last;
    } result_t;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic s_valid = 1'b0;
    logic s_ready;
    logic [2:0] s_kind = '0;
    logic s_preemptable = 1'b0;
    logic [7:0] s_cpu_index = '0;
    logic [63:0] s_thread_key = '0;
    logic [31:0] s_handle = '0;
    logic m_valid;
    logic m_ready = 1'b0;
    logic [1:0] m_status;
    logic m_released;
    logic [31:0] m_released_handle;
    logic signed [63:0] m_safe_epoch;
    logic m_last;
    logic cfg_valid = 1'b0;
    logic cfg_ready;
    logic [1:0] cfg_index = '0;
    logic [4:0] cfg_data = '0;

    epoch_reclamation_tracker dut (.*);

    always #5 aclk = ~aclk;

    // Model state.
    logic          mdl_percpu;
    logic [4:0]    mdl_cpus;
    epoch_t        mdl_epoch;
    epoch_t        mdl_cpu_ep [NCPU];
    logic          mdl_thr_v [NTHR];
    logic [63:0]   mdl_thr_key [NTHR];
    epoch_t        mdl_thr_ep [NTHR];
    logic [31:0]   mdl_q_handle [NFREE];
    epoch_t        mdl_q_ep [NFREE];
    int            mdl_head, mdl_count;

    result_t expected_words[$];
    int errors = 0;
    int words_seen = 0;
    int releases_seen = 0;
    longint unsigned cycles = 0;
    int gap_mode = 0;   // 0 random gaps, 1 no gaps

    function automatic int cpus_in_use();
        return (mdl_cpus < NCPU) ? int'(mdl_cpus) : NCPU;
    endfunction

    function automatic logic thread_store(logic [63:0] key, epoch_t value);
        int spare;
        spare = -1;
        for (int i = 0; i < NTHR; i++) begin
            if (mdl_thr_v[i] && mdl_thr_key[i] == key) begin
                mdl_thr_ep[i] = value;
                return 1'b1;
            end
            if (!mdl_thr_v[i] && spare < 0) spare = i;
        end
        if (spare < 0) return 1'b0;
        mdl_thr_v[spare] = 1'b1;
        mdl_thr_key[spare] = key;
        mdl_thr_ep[spare] = value;
        return 1'b1;
    endfunction

    // Release queue heads at or below limit (all when every_one is set).
    function automatic void release_handles(epoch_t limit, logic every_one,
                                            logic [63:0] safe);
        int n;
        result_t w;
        n = 0;
        while (mdl_count > 0) begin
            if (!every_one && mdl_q_ep[mdl_head] > limit) break;
            w = '{ST_OK, 1'b1, mdl_q_handle[mdl_head], safe, 1'b0};
            expected_words.push_back(w);
            n++;
            mdl_head = (mdl_head + 1) % NFREE;
            mdl_count--;
        end
        if (n == 0) begin
            w = '{ST_OK, 1'b0, 32'd0, safe, 1'b1};
            expected_words.push_back(w);
        end else begin
            expected_words[$].last = 1'b1;
        end
    endfunction

    function automatic void predict_command(logic [2:0] kind, logic pre,
                                            logic [7:0] cpu, logic [63:0] key,
                                            logic [31:0] handle);
        logic by_thread, cpu_ok;
        logic [1:0] st;
        epoch_t low;
        result_t w;
        by_thread = pre || !mdl_percpu;
        cpu_ok = mdl_percpu && (int'(cpu) < cpus_in_use());
        st = ST_OK;
        case (kind)
            KIND_ENTER, KIND_EXIT: begin
                if (by_thread) begin
                    if (!thread_store(key, kind == KIND_ENTER ? mdl_epoch : '0))
                        st = ST_THR_FULL;
                end else if (cpu_ok) begin
                    mdl_cpu_ep[cpu[3:0]] = mdl_epoch;
                end else begin
                    st = ST_CPU_RANGE;
                end
            end
            KIND_FREE: begin
                if (mdl_count >= NFREE) begin
                    st = ST_FIFO_FULL;
                end else begin
                    mdl_q_handle[(mdl_head + mdl_count) % NFREE] = handle;
                    mdl_q_ep[(mdl_head + mdl_count) % NFREE] = mdl_epoch;
                    mdl_count++;
                    if (mdl_epoch != EPOCH_MAX) mdl_epoch = mdl_epoch + 1'b1;
                end
            end
            KIND_FLUSH: begin
                low = EPOCH_MAX;
                if (mdl_percpu)
                    for (int i = 0; i < cpus_in_use(); i++)
                        if (mdl_cpu_ep[i] != 0 && mdl_cpu_ep[i] < low) low = mdl_cpu_ep[i];
                for (int i = 0; i < NTHR; i++)
                    if (mdl_thr_v[i] && mdl_thr_ep[i] != 0 && mdl_thr_ep[i] < low)
                        low = mdl_thr_ep[i];
                release_handles(low - 1'b1, low == EPOCH_MAX, {1'b0, low - 1'b1});
                return;
            end
            KIND_REFRESH: begin
                if (cpu_ok) mdl_cpu_ep[cpu[3:0]] = mdl_epoch;
                else st = ST_CPU_RANGE;
            end
            KIND_DRAIN: begin
                release_handles(EPOCH_MAX, 1'b1, {1'b0, EPOCH_MAX});
                return;
            end
            default: ;
        endcase
        w = '{st, 1'b0, 32'd0, 64'd0, 1'b1};
        expected_words.push_back(w);
    endfunction

    function automatic int pick_gap();
        int r;
        if (gap_mode == 1) return 0;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 93) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // Cycle counter and watchdog.
    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles > LIMIT_CYCLES) begin
            $display("%0t: timeout, %0d words still expected", $realtime,
                     expected_words.size());
            $display("CHECK FAILED");
            $finish;
        end
    end

    // Result checker with random backpressure.
    initial begin : check_results
        result_t got, want;
        int stall;
        stall = 0;
        forever begin
            @(posedge aclk);
            if (aresetn && m_valid && m_ready) begin
                got = '{m_status, m_released, m_released_handle, m_safe_epoch, m_last};
                words_seen++;
                if (m_released) releases_seen++;
                if (expected_words.size() == 0) begin
                    $display("%0t: unexpected word %p", $realtime, got);
                    errors++;
                end else begin
                    want = expected_words.pop_front();
                    if (got.status !== want.status)
                        $display("%0t: status exp %0d got %0d", $realtime,
                                 want.status, got.status);
                    if (got.released !== want.released)
                        $display("%0t: released exp %0d got %0d", $realtime,
                                 want.released, got.released);
                    if (got.rhandle !== want.rhandle)
                        $display("%0t: released_handle exp %h got %h", $realtime,
                                 want.rhandle, got.rhandle);
                    if (got.safe !== want.safe)
                        $display("%0t: safe_epoch exp %h got %h", $realtime,
                                 want.safe, got.safe);
                    if (got.last !== want.last)
                        $display("%0t: last exp %0d got %0d", $realtime,
                                 want.last, got.last);
                    if (got !== want) errors++;
                end
            end
            if (stall > 0) begin
                stall--;
                m_ready <= 1'b0;
            end else begin
                stall = pick_gap();
                m_ready <= (stall == 0);
            end
        end
    end

    // Send one command word and record its expected results. The word is
    // driven after a gap from pick_gap that follows the previous acceptance;
    // the block is busy right after an acceptance in any case.
    task automatic send_command(logic [2:0] kind, logic pre, logic [7:0] cpu,
                                logic [63:0] key, logic [31:0] handle);
        int gap;
        gap = pick_gap();
        repeat (gap + 1) @(posedge aclk);
        s_valid <= 1'b1;
        s_kind <= kind;
        s_preemptable <= pre;
        s_cpu_index <= cpu;
        s_thread_key <= key;
        s_handle <= handle;
        do @(posedge aclk); while (!s_ready);
        predict_command(kind, pre, cpu, key, handle);
        s_valid <= 1'b0;
    endtask

    task automatic wait_idle();
        while (expected_words.size() != 0) @(posedge aclk);
        repeat (100) @(posedge aclk);
    endtask

    task automatic write_register(logic [1:0] idx, logic [4:0] data);
        wait_idle();
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        if (idx == CFG_PERCPU) mdl_percpu = data[0];
        else if (idx == CFG_CPU_COUNT) mdl_cpus = data;
    endtask

    function automatic logic [63:0] rand_key64();
        return {$urandom(), $urandom()};
    endfunction

    // Directed: every kind, range errors, a full free queue, empty flush and drain.
    task automatic test_directed();
        send_command(KIND_FLUSH, 0, 0, 0, 0);
        send_command(KIND_DRAIN, 0, 0, 0, 0);
        send_command(KIND_FREE, 0, 0, 0, 32'hFFFF_FFFF);
        send_command(KIND_FREE, 0, 0, 0, 32'h0);
        send_command(KIND_ENTER, 0, 8'd15, 0, 0);
        send_command(KIND_ENTER, 0, 8'd16, 0, 0);
        send_command(KIND_REFRESH, 0, 8'd255, 0, 0);
        send_command(KIND_ENTER, 1, 0, 64'hFFFF_FFFF_FFFF_FFFF, 0);
        send_command(KIND_FLUSH, 0, 0, 0, 0);
        send_command(KIND_EXIT, 1, 0, 64'hFFFF_FFFF_FFFF_FFFF, 0);
        send_command(KIND_EXIT, 0, 8'd15, 0, 0);
        send_command(KIND_REFRESH, 0, 8'd0, 0, 0);
        send_command(3'd6, 1, 8'hAA, 64'h5555, 32'h1234);
        send_command(3'd7, 0, 0, 0, 0);
        send_command(KIND_DRAIN, 0, 0, 0, 0);
        // Fill the free queue past its depth.
        for (int i = 0; i < NFREE + 2; i++) send_command(KIND_FREE, 0, 0, 0, $urandom());
        send_command(KIND_FLUSH, 0, 0, 0, 0);
        send_command(KIND_DRAIN, 0, 0, 0, 0);
    endtask

    task automatic test_thread_full();
        for (int i = 0; i < NTHR + 2; i++)
            send_command(i[0] ? KIND_EXIT : KIND_ENTER, 1, 0, 64'h1000 + i, 0);
        send_command(KIND_ENTER, 1, 0, 64'h1000, 0);
        send_command(KIND_FLUSH, 0, 0, 0, 0);
    endtask

    // Random traffic: mostly readers and frees with frequent flushes.
    task automatic test_random(int count, int key_span);
        int r;
        logic [2:0] kind;
        for (int i = 0; i < count; i++) begin
            r = $urandom_range(0, 99);
            if (r < 25) kind = KIND_ENTER;
            else if (r < 40) kind = KIND_EXIT;
            else if (r < 65) kind = KIND_FREE;
            else if (r < 83) kind = KIND_FLUSH;
            else if (r < 92) kind = KIND_REFRESH;
            else if (r < 96) kind = KIND_DRAIN;
            else kind = 3'($urandom_range(6, 7));
            send_command(kind, 1'($urandom()),
                         ($urandom_range(0, 9) == 0) ? 8'($urandom()) : 8'($urandom_range(0, 17)),
                         ($urandom_range(0, 19) == 0) ? rand_key64()
                             : 64'($urandom_range(0, key_span)),
                         $urandom());
            if (i == count / 2) wait_idle();
        end
    endtask

    initial begin : run
        mdl_percpu = 1'b1;
        mdl_cpus = 5'd16;
        mdl_epoch = 1;
        for (int i = 0; i < NCPU; i++) mdl_cpu_ep[i] = 1;
        for (int i = 0; i < NTHR; i++) mdl_thr_v[i] = 1'b0;
        mdl_head = 0;
        mdl_count = 0;
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_directed();
        write_register(CFG_PERCPU, 5'd0);
        send_command(KIND_ENTER, 0, 8'd3, 64'h77, 0);
        send_command(KIND_REFRESH, 0, 8'd3, 0, 0);
        test_random(50, 10);
        write_register(CFG_PERCPU, 5'd1);
        write_register(CFG_CPU_COUNT, 5'd0);
        test_random(50, 10);
        write_register(CFG_CPU_COUNT, 5'd31);
        gap_mode = 1;
        test_random(60, 20);
        gap_mode = 0;
        write_register(CFG_CPU_COUNT, 5'd5);
        test_random(80, 25);
        test_thread_full();
        write_register(CFG_CPU_COUNT, 5'd16);
        test_random(80, 40);

        wait_idle();
        $display("Ran all kinds over several register settings: %0d result words, %0d releases.",
                 words_seen, releases_seen);
        if (errors == 0 && expected_words.size() == 0) begin
            $display("CHECK OK");
        end else begin
            $display("%0d mismatches", errors);
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule

`default_nettype wire
